### hw/rtl/pcbd_pkg.sv
`default_nettype none

package pcbd_pkg;

   localparam int NUM_ENTRIES  = 256;
   localparam int MAX_CODE_LEN = 32;

   localparam int INDEX_W   = 8;
   localparam int SYMBOL_W  = 8;
   localparam int CODE_W    = 32;
   localparam int LENGTH_W  = 6;
   localparam int CODE_IX_W = $clog2(CODE_W);

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_BIT  = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [INDEX_W-1:0]  entry_index;
      logic [SYMBOL_W-1:0] entry_symbol;
      logic [CODE_W-1:0]   entry_code;
      logic [LENGTH_W-1:0] entry_length;
      logic                code_bit;
   } req_word_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                status;
   } rsp_word_type;

   // token walking the row of cells during one bit item
   typedef struct packed {
      logic                valid;
      logic                any;
      logic                hit;
      logic [SYMBOL_W-1:0] symbol;
   } token_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                load;
      logic                restart;
      logic [INDEX_W-1:0]  index;
      logic [SYMBOL_W-1:0] symbol;
      logic [CODE_W-1:0]   code;
      logic [LENGTH_W-1:0] length;
      logic                code_bit;
      logic [LENGTH_W-1:0] pos;
   } ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/pcbd_cell.sv
`default_nettype none

module pcbd_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pcbd_pkg::ctrl_type           ctrl,
   input  wire logic [pcbd_pkg::INDEX_W-1:0] cell_index,
   input  wire pcbd_pkg::token_type          tok_i,
   output pcbd_pkg::token_type               tok_o
);

   logic [pcbd_pkg::LENGTH_W-1:0] length_ff, length_in;
   logic [pcbd_pkg::CODE_W-1:0]   code_ff;
   logic [pcbd_pkg::SYMBOL_W-1:0] symbol_ff;
   logic                          match_ff, match_in;
   pcbd_pkg::token_type           tok_ff, tok_in;

   logic                          write_en;
   logic                          long_enough;
   logic [pcbd_pkg::LENGTH_W-1:0] shift;
   logic                          code_bit;
   logic                          matched;
   logic                          complete;

   assign write_en = ctrl.load && (ctrl.index == cell_index);

   // over-long codes leave the slot empty
   assign length_in = (32'(ctrl.length) > pcbd_pkg::MAX_CODE_LEN) ? '0 : ctrl.length;

   assign long_enough = length_ff > ctrl.pos;
   assign shift       = length_ff - pcbd_pkg::LENGTH_W'(1) - ctrl.pos;
   assign code_bit    = (32'(shift) < pcbd_pkg::CODE_W) ?
                        code_ff[shift[pcbd_pkg::CODE_IX_W-1:0]] : 1'b0;
   assign matched     = tok_i.valid && match_ff && long_enough && (code_bit == ctrl.code_bit);
   assign complete    = matched &&
                        ((pcbd_pkg::LENGTH_W+1)'(length_ff) ==
                         (pcbd_pkg::LENGTH_W+1)'(ctrl.pos) + (pcbd_pkg::LENGTH_W+1)'(1));

   always_comb begin
      match_in = match_ff;
      if (ctrl.restart) begin
         match_in = 1'b1;
      end else if (tok_i.valid && !matched) begin
         match_in = 1'b0;
      end
   end

   always_comb begin
      tok_in       = tok_i;
      tok_in.any   = tok_i.any | matched;
      // lower index wins, so a hit already carried is kept
      if (complete && !tok_i.hit) begin
         tok_in.hit    = 1'b1;
         tok_in.symbol = symbol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         match_ff  <= 1'b1;
         tok_ff    <= '0;
      end else begin
         if (write_en) begin
            length_ff <= length_in;
         end
         match_ff <= match_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         code_ff   <= ctrl.code;
         symbol_ff <= ctrl.symbol;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

### hw/rtl/prefix_code_bit_decoder.sv
// Load word: gives no result; the next word may follow at once.
// Bit word: a token walks the row of NUM_ENTRIES cells, one cell a cycle, and busy stays
//   high until it leaves the last cell; a result, if any, is then registered and strobed.
//   No new word is taken while busy, so one bit word passes the row before another is accepted.
// Results are strobed for one cycle and cannot be held off.
// Synchronous reset empties every slot and restarts decoding.
`default_nettype none

module prefix_code_bit_decoder (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire pcbd_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   output pcbd_pkg::rsp_word_type      rsp_word
);

   localparam int IW = pcbd_pkg::INDEX_W;

   pcbd_pkg::state_type           state_ff, state_in;
   logic [pcbd_pkg::LENGTH_W-1:0] pos_ff, pos_in;
   logic                          bit_ff;
   logic                          launch_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   pcbd_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;

   pcbd_pkg::token_type           tok [pcbd_pkg::NUM_ENTRIES+1];
   pcbd_pkg::token_type           tok_last;
   pcbd_pkg::ctrl_type            ctrl;

   logic accept;
   logic load_en;
   logic launch_in;
   logic finish;
   logic restart_scan;

   assign accept = start && !busy;
   assign tok_last = tok[pcbd_pkg::NUM_ENTRIES];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcbd_pkg::ST_IDLE: begin
            if (accept && req_word.mode == pcbd_pkg::MODE_BIT) begin
               state_in = pcbd_pkg::ST_SCAN;
            end
         end
         pcbd_pkg::ST_SCAN: begin
            if (tok_last.valid) begin
               state_in = pcbd_pkg::ST_IDLE;
            end
         end
         default: state_in = pcbd_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      busy      = 1'b0;
      finish    = 1'b0;
      load_en   = 1'b0;
      launch_in = 1'b0;
      unique case (state_ff)
         pcbd_pkg::ST_IDLE: begin
            load_en   = accept && (req_word.mode == pcbd_pkg::MODE_LOAD);
            launch_in = accept && (req_word.mode == pcbd_pkg::MODE_BIT);
         end
         pcbd_pkg::ST_SCAN: begin
            busy   = 1'b1;
            finish = tok_last.valid;
         end
         default: busy = 1'b0;
      endcase
   end

   assign restart_scan = finish && (tok_last.hit || !tok_last.any);

   always_comb begin
      ctrl.load     = load_en;
      ctrl.restart  = load_en || restart_scan;
      ctrl.index    = req_word.entry_index;
      ctrl.symbol   = req_word.entry_symbol;
      ctrl.code     = req_word.entry_code;
      ctrl.length   = req_word.entry_length;
      ctrl.code_bit = bit_ff;
      ctrl.pos      = pos_ff;
   end

   always_comb begin
      pos_in = pos_ff;
      if (ctrl.restart) begin
         pos_in = '0;
      end else if (finish) begin
         pos_in = pos_ff + pcbd_pkg::LENGTH_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in       = restart_scan;
      rsp_word_in.symbol = tok_last.hit ? tok_last.symbol : '0;
      rsp_word_in.status = tok_last.hit ? pcbd_pkg::STATUS_OK : pcbd_pkg::STATUS_ERROR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcbd_pkg::ST_IDLE;
         pos_ff       <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (launch_in) begin
         bit_ff <= req_word.code_bit;
      end
      if (restart_scan) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_comb begin
      tok[0].valid  = launch_ff;
      tok[0].any    = 1'b0;
      tok[0].hit    = 1'b0;
      tok[0].symbol = '0;
   end

   for (genvar i = 0; i < pcbd_pkg::NUM_ENTRIES; i++) begin : g_cell
      pcbd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cell_index (IW'(i)),
         .tok_i      (tok[i]),
         .tok_o      (tok[i+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while a bit word is still in the row");

   a_bit_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.mode == pcbd_pkg::MODE_BIT) |=> (busy && launch_ff))
      else $error("accepted bit word did not launch a token");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_last.valid |-> (state_ff == pcbd_pkg::ST_SCAN))
      else $error("token left the row outside a scan");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < pcbd_pkg::MAX_CODE_LEN)
      else $error("bit count ran past the longest code");

endmodule

`default_nettype wire
